>>> hdl/bnv_pkg.sv
// Shared types and constants for the batch-normalization vector unit.
// Depends on nothing; bnv_lane, the top level and the testbench import it.
package bnv_pkg;

    // Q8.8 data word and the widths of the lane datapath
    localparam int WORD_W   = 16;
    localparam int DIFF_W   = WORD_W + 1;          // x - mean
    localparam int SCALE_W  = 2 * WORD_W;          // rvar * gamma
    localparam int PROD_W   = DIFF_W + SCALE_W;    // (x - mean) * scale
    localparam int SUM_W    = PROD_W + 1;          // plus beta and rounding
    localparam int FRAC_OUT = 24;                  // fraction bits of the sum
    localparam int BETA_SHIFT = 16;                // beta aligned to 24 fraction bits
    localparam int SAT_MSB  = FRAC_OUT + WORD_W - 1;

    localparam logic signed [WORD_W-1:0] Y_MAX = 16'sh7FFF;
    localparam logic signed [WORD_W-1:0] Y_MIN = 16'sh8000;

    // Item layout
    localparam int IDX_W       = 8;
    localparam int IDX_ENTRIES = 2 ** IDX_W;
    localparam int NUM_Y       = 8;                // lane fields on the bus
    localparam int IN_TDATA_W  = IDX_W + WORD_W + NUM_Y * WORD_W;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = NUM_Y * WORD_W;
    localparam int WVAL_LSB    = IDX_W;
    localparam int X_LSB       = IDX_W + WORD_W;

    // Configuration port
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_ADDR_LSB = 2;
    localparam int REG_IDX_W    = PADDR_W - REG_ADDR_LSB;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_MODE = 1'b0;

    localparam int NUM_TABLES  = 4;
    localparam int LANE_STAGES = 3;                // registered stages after the table read

    typedef enum logic
    {
        FUNC_COMPUTE = 1'b0,
        FUNC_LOAD    = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        SEL_MEAN  = 2'd0,
        SEL_RVAR  = 2'd1,
        SEL_GAMMA = 2'd2,
        SEL_BETA  = 2'd3
    } param_sel_t;

    typedef enum logic
    {
        MODE_PER_LANE  = 1'b0,
        MODE_BROADCAST = 1'b1
    } wmode_t;

    // Control that the top level drives into every lane
    typedef struct packed
    {
        logic                   rd_en;   // compute item accepted: read the tables
        logic                   wr_en;   // load item accepted: write one table
        param_sel_t             wr_sel;
        logic [LANE_STAGES-1:0] adv;     // stage enables, bit 0 is the first stage
    } lane_ctrl_t;

endpackage

>>> hdl/bnv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bnv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bnv_lane.sv
// One normalization lane: its own copy of the four weight tables and a
// four-stage fixed-point datapath. Depends on bnv_pkg and bnv_ram.
module bnv_lane #(
    parameter int CHANNELS = 256
) (
    input  logic                                 clk,
    input  bnv_pkg::lane_ctrl_t                  ctrl,
    input  logic [$clog2(CHANNELS)-1:0]          wr_addr,
    input  logic signed [bnv_pkg::WORD_W-1:0]    wr_data,
    input  logic [$clog2(CHANNELS)-1:0]          rd_addr,
    input  logic signed [bnv_pkg::WORD_W-1:0]    x,
    output logic signed [bnv_pkg::WORD_W-1:0]    y
);
    import bnv_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(2 ** (FRAC_OUT - 1));

    logic [WORD_W-1:0]        tbl_data [NUM_TABLES];
    logic signed [WORD_W-1:0] mean_w;
    logic signed [WORD_W-1:0] rvar_w;
    logic signed [WORD_W-1:0] gamma_w;
    logic signed [WORD_W-1:0] beta_w;

    logic signed [WORD_W-1:0]  x0_reg;
    logic signed [DIFF_W-1:0]  diff_reg,  diff_next;
    logic signed [SCALE_W-1:0] scale_reg, scale_next;
    logic signed [WORD_W-1:0]  beta1_reg;
    logic signed [PROD_W-1:0]  prod_reg,  prod_next;
    logic signed [WORD_W-1:0]  beta2_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:SAT_MSB]    sum_hi;
    logic signed [WORD_W-1:0]  y_reg,     y_next;

    // Every lane keeps a full copy of each table so that it can read its own
    // entry in the same cycle as the other lanes.
    for (genvar t = 0; t < NUM_TABLES; t++)
    begin : g_table
        bnv_ram #(
            .WIDTH (WORD_W),
            .DEPTH (CHANNELS)
        ) u_ram (
            .clk   (clk),
            .we    (ctrl.wr_en && (ctrl.wr_sel == param_sel_t'(t))),
            .waddr (wr_addr),
            .wdata (wr_data),
            .re    (ctrl.rd_en),
            .raddr (rd_addr),
            .rdata (tbl_data[t])
        );
    end

    assign mean_w  = tbl_data[SEL_MEAN];
    assign rvar_w  = tbl_data[SEL_RVAR];
    assign gamma_w = tbl_data[SEL_GAMMA];
    assign beta_w  = tbl_data[SEL_BETA];

    always_comb
    begin
        diff_next  = DIFF_W'(x0_reg) - DIFF_W'(mean_w);
        scale_next = rvar_w * gamma_w;
        prod_next  = diff_reg * scale_reg;
        sum_next   = SUM_W'(prod_reg) + (SUM_W'(beta2_reg) <<< BETA_SHIFT) + ROUND_BIAS;
        sum_hi     = sum_next[SUM_W-1:SAT_MSB];
        // In range when all bits above the result's sign bit agree with it.
        if ((&sum_hi) || !(|sum_hi))
        begin
            y_next = sum_next[SAT_MSB:FRAC_OUT];
        end
        else if (sum_next[SUM_W-1])
        begin
            y_next = Y_MIN;
        end
        else
        begin
            y_next = Y_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            x0_reg <= x;
        end
        if (ctrl.adv[0])
        begin
            diff_reg  <= diff_next;
            scale_reg <= scale_next;
            beta1_reg <= beta_w;
        end
        if (ctrl.adv[1])
        begin
            prod_reg  <= prod_next;
            beta2_reg <= beta1_reg;
        end
        if (ctrl.adv[2])
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

>>> hdl/batch_norm_vector_unit.sv
// Top level of the eight-lane batch-normalization vector unit: stream ports,
// register port, address generation, pipeline control and result merging.
// Depends on bnv_pkg, bnv_lane and bnv_ram.
//
// Usage. Items arrive on the s_ stream. An item with func = load writes one
// Q8.8 word into the mean, reciprocal root variance, gamma or beta table at
// entry channel_index (modulo CHANNELS); it gives no result. An item with
// func = compute carries eight activations and returns one item on the m_
// stream holding y = (x - mean) * (rvar * gamma) + beta for each lane,
// rounded to nearest (halves upwards) and saturated to Q8.8. Lanes at or
// beyond LANES read as zero. The weight_mode register (address 0) chooses
// per-lane entries (channel_index*LANES+lane) modulo CHANNELS or one entry for every lane.
// Throughput is one item per cycle while the receiver does not stall, through
// the four-stage lane datapath, each lane having a private copy of the tables
// read through its own port. A compute result passes the table read, the lane
// stages and the output register. When the receiver stalls, results queue
// there; up to five results are held before s_tready falls. Reset clears
// weight_mode and all valid flags; the tables are not cleared and must be
// loaded before use. The user must write configuration only while no item
// is in flight; the block itself does not enforce it.
module batch_norm_vector_unit #(
    parameter int CHANNELS = 256,
    parameter int LANES    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // channel_index[7:0], weight_value[23:8], x_lane0[39:24] .. x_lane7[151:136]
    input  logic [bnv_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[0], param_select[2:1]
    input  logic [bnv_pkg::IN_TUSER_W-1:0]    s_tuser,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // y_lane0[15:0], y_lane1[31:16] .. y_lane7[127:112]
    output logic [bnv_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bnv_pkg::PADDR_W-1:0]       paddr,
    input  logic [bnv_pkg::PDATA_W-1:0]       pwdata,
    output logic [bnv_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import bnv_pkg::*;

    localparam int ADDR_W = $clog2(CHANNELS);
    localparam logic [ADDR_W:0] CH_L = (ADDR_W + 1)'(CHANNELS);

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    wmode_t               weight_mode_reg, weight_mode_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:REG_ADDR_LSB];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        weight_mode_next = weight_mode_reg;
        if (cfg_wr && (reg_idx == REG_WEIGHT_MODE))
        begin
            weight_mode_next = wmode_t'(pwdata[0]);
        end
        prdata = '0;
        if (reg_idx == REG_WEIGHT_MODE)
        begin
            prdata = PDATA_W'(weight_mode_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    func_t                    in_func;
    param_sel_t               in_sel;
    logic [IDX_W-1:0]         in_idx;
    logic signed [WORD_W-1:0] in_wval;

    assign in_func = func_t'(s_tuser[0]);
    assign in_sel  = param_sel_t'(s_tuser[2:1]);
    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_wval = s_tdata[WVAL_LSB +: WORD_W];

    // ------------------------------------------------------------------
    // Pipeline control. Each stage moves on when it is empty or the stage
    // after it moves, so bubbles close up while the output is stalled.
    // ------------------------------------------------------------------
    logic [LANE_STAGES:0] vld_reg, vld_next;   // bit 0 holds the table read stage
    logic                 m_valid_reg, m_valid_next;
    logic                 out_en;
    logic [LANE_STAGES:0] stage_en;
    logic                 accept;
    logic                 comp_accept;
    lane_ctrl_t           ctrl;

    always_comb
    begin
        out_en = !m_valid_reg || m_tready;
        stage_en[LANE_STAGES] = !vld_reg[LANE_STAGES] || out_en;
        for (int k = LANE_STAGES - 1; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready    = stage_en[0];
    assign accept      = s_tvalid && s_tready;
    assign comp_accept = accept && (in_func == FUNC_COMPUTE);

    assign ctrl.rd_en  = comp_accept;
    assign ctrl.wr_en  = accept && (in_func == FUNC_LOAD);
    assign ctrl.wr_sel = in_sel;
    assign ctrl.adv    = stage_en[LANE_STAGES:1];

    always_comb
    begin
        vld_next = vld_reg;
        if (stage_en[0])
        begin
            vld_next[0] = comp_accept;
        end
        for (int k = 1; k <= LANE_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
        m_valid_next = out_en ? vld_reg[LANE_STAGES] : m_valid_reg;
    end

    // ------------------------------------------------------------------
    // Table addresses. The index is only eight bits wide, so its products
    // with LANES and its remainders by CHANNELS come from constant tables.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] base_tbl [IDX_ENTRIES];   // (idx * LANES) mod CHANNELS
    logic [ADDR_W-1:0] bcast_tbl [IDX_ENTRIES];  // idx mod CHANNELS
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] bcast_addr;

    for (genvar i = 0; i < IDX_ENTRIES; i++)
    begin : g_addr_tbl
        localparam int BASE_V  = (i * LANES) % CHANNELS;
        localparam int BCAST_V = i % CHANNELS;
        assign base_tbl[i]  = ADDR_W'(BASE_V);
        assign bcast_tbl[i] = ADDR_W'(BCAST_V);
    end

    assign base_addr  = base_tbl[in_idx];
    assign bcast_addr = bcast_tbl[in_idx];

    // ------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]        lane_addr [LANES];
    logic signed [WORD_W-1:0] lane_y    [LANES];

    for (genvar v = 0; v < LANES; v++)
    begin : g_lane
        localparam logic [ADDR_W:0] OFFSET = (ADDR_W + 1)'(v);
        logic [ADDR_W:0] addr_sum;

        // base < CHANNELS and the lane offset < LANES; with LANES <= CHANNELS one
        // subtraction brings the sum back into range.
        always_comb
        begin
            addr_sum = {1'b0, base_addr} + OFFSET;
            if (addr_sum >= CH_L)
            begin
                addr_sum = addr_sum - CH_L;
            end
            if (weight_mode_reg == MODE_BROADCAST)
            begin
                lane_addr[v] = bcast_addr;
            end
            else
            begin
                lane_addr[v] = addr_sum[ADDR_W-1:0];
            end
        end

        bnv_lane #(
            .CHANNELS (CHANNELS)
        ) u_lane (
            .clk     (clk),
            .ctrl    (ctrl),
            .wr_addr (bcast_addr),
            .wr_data (in_wval),
            .rd_addr (lane_addr[v]),
            .x       (s_tdata[X_LSB + v * WORD_W +: WORD_W]),
            .y       (lane_y[v])
        );
    end

    // ------------------------------------------------------------------
    // Merging stage: the lane results are packed into the output register.
    // ------------------------------------------------------------------
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    for (genvar v = 0; v < NUM_Y; v++)
    begin : g_pack
        if (v < LANES)
        begin : g_used
            assign m_data_next[v * WORD_W +: WORD_W] = lane_y[v];
        end
        else
        begin : g_unused
            assign m_data_next[v * WORD_W +: WORD_W] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_mode_reg <= MODE_PER_LANE;
            vld_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            weight_mode_reg <= weight_mode_next;
            vld_reg         <= vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A result only ever comes out of the last lane stage.
    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[LANE_STAGES]))
        else $error("output became valid without a finished compute item");

    // A load item never occupies a pipeline slot.
    a_load_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_func == FUNC_LOAD)) |=> !vld_reg[0])
        else $error("load item entered the compute pipeline");

    // With every stage full and the output stalled, no item may be taken.
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && (&vld_reg)) |-> !s_tready)
        else $error("item accepted while the pipeline was full and stalled");

    // A held result must not be overwritten while the output is stalled.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && (m_tdata == $past(m_tdata))))
        else $error("stalled result lost or changed");

endmodule

>>> tb/sv/batch_norm_vector_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for batch_norm_vector_unit: random and directed load and compute
// items, a bit-exact Q8.8 predictor and a per-lane comparison of every result item.
// Depends on bnv_pkg and the batch_norm_vector_unit RTL.
module batch_norm_vector_unit_tb;

    import bnv_pkg::*;

    localparam int     N_CHAN         = 256;
    localparam int     N_LANE         = 8;
    // Cycles that wait_idle lets pass after the last item and result of a phase.
    localparam int     DRAIN_CYCLES   = 8;
    // Length of the deliberate receiver hold-off that fills the pipeline.
    localparam int     HOLD_CYCLES    = 80;
    // Cycles without any handshake before the run is declared hung.
    localparam int     WATCHDOG_LIMIT = 4000;
    // 32768 in Q8.8 carried to 24 fraction bits: the first value that saturates upwards.
    localparam longint SAT_BOUND      = longint'(1) << 39;
    localparam longint HALF_LSB       = longint'(1) << 23;

    typedef logic [N_LANE-1:0][WORD_W-1:0] lanes_t;

    // One item on the input stream; x is packed so that lane 0 sits in the low bits.
    typedef struct packed
    {
        func_t             func;
        param_sel_t        sel;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] wval;
        lanes_t            x;
    } bn_item_t;

    // Block ports. Every input starts from a known value.
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // Predictor state: the four weight tables and the mode register as the block should hold them.
    logic signed [WORD_W-1:0] mean_tab  [N_CHAN];
    logic signed [WORD_W-1:0] rvar_tab  [N_CHAN];
    logic signed [WORD_W-1:0] gamma_tab [N_CHAN];
    logic signed [WORD_W-1:0] beta_tab  [N_CHAN];
    wmode_t                   cfg_mode = MODE_PER_LANE;

    // Items waiting to be driven, and normalised vectors waiting to come out.
    bn_item_t item_queue [$];
    lanes_t   y_expect   [$];
    bn_item_t cur_item;

    // Which table entries the stimulus has written so far. Computes only read written entries.
    bit       loaded [NUM_TABLES][N_CHAN];
    logic [IDX_W-1:0] last_idx = '0;

    int items_queued   = 0;
    int items_accepted = 0;
    int error_count    = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int src_wait       = 0;
    int sink_wait      = 0;
    int hold_asks      = 0;
    int hold_served    = 0;
    int quiet_cycles   = 0;

    batch_norm_vector_unit #(
        .CHANNELS (N_CHAN),
        .LANES    (N_LANE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One lane of y = (x - mean) * (rvar * gamma) + beta, carried exactly with 24 fraction
    // bits, rounded with halves going upwards and saturated to Q8.8.
    function automatic logic signed [WORD_W-1:0] norm_lane_q88(logic signed [WORD_W-1:0] x,
                                                               int e);
        longint diff;
        longint scale;
        longint acc;
        diff  = longint'(x) - longint'(mean_tab[e]);
        scale = longint'(rvar_tab[e]) * longint'(gamma_tab[e]);
        acc   = diff * scale + (longint'(beta_tab[e]) <<< 16) + HALF_LSB;
        if (acc >= SAT_BOUND)
            return 16'sh7FFF;
        if (acc < -SAT_BOUND)
            return 16'sh8000;
        // An arithmetic shift of a signed value is a floor division.
        return WORD_W'(acc >>> 24);
    endfunction

    // Applies one accepted item: a load updates a table, a compute queues its result.
    function automatic void bn_apply(bn_item_t it);
        lanes_t y;
        int     e;
        if (it.func == FUNC_LOAD)
        begin
            case (it.sel)
                SEL_MEAN:  mean_tab[it.idx]  = it.wval;
                SEL_RVAR:  rvar_tab[it.idx]  = it.wval;
                SEL_GAMMA: gamma_tab[it.idx] = it.wval;
                default:   beta_tab[it.idx]  = it.wval;
            endcase
        end
        else
        begin
            for (int v = 0; v < N_LANE; v++)
            begin
                if (cfg_mode == MODE_BROADCAST)
                    e = int'(it.idx);
                else
                    e = (int'(it.idx) * N_LANE + v) % N_CHAN;
                y[v] = norm_lane_q88(it.x[v], e);
            end
            y_expect.push_back(y);
        end
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Gap length for either side: usually none, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 15);
        return $urandom_range(3, 1);
    endfunction

    // A Q8.8 word. Fully random words mostly saturate the result, so a good share is kept
    // small or near one so that the rounding is exercised as well.
    function automatic logic [WORD_W-1:0] rand_q88();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return WORD_W'($urandom);
        if (r < 6)
            return WORD_W'($urandom_range(1536) - 768);
        if (r == 6)
        begin
            case ($urandom_range(4))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'h0001;
                default: return 16'hFFFF;
            endcase
        end
        return WORD_W'(256 + $urandom_range(128) - 64);
    endfunction

    function automatic lanes_t rand_lanes();
        lanes_t x;
        for (int v = 0; v < N_LANE; v++)
            x[v] = rand_q88();
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic queue_item(bn_item_t it);
        item_queue.push_back(it);
        items_queued++;
    endtask

    // A load item; its lane fields carry noise, which the block must ignore.
    task automatic queue_load(param_sel_t sel, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        bn_item_t it;
        it.func = FUNC_LOAD;
        it.sel  = sel;
        it.idx  = idx;
        it.wval = val;
        it.x    = rand_lanes();
        loaded[sel][idx] = 1'b1;
        queue_item(it);
    endtask

    // A compute item. Any table entry that it reads and that was never written is loaded
    // first, so the item always ends a well-formed load-then-compute sequence. Its
    // selector and weight word carry noise.
    task automatic queue_compute(logic [IDX_W-1:0] idx, lanes_t x);
        bn_item_t it;
        int       e;
        for (int v = 0; v < N_LANE; v++)
        begin
            if (cfg_mode == MODE_BROADCAST)
                e = int'(idx);
            else
                e = (int'(idx) * N_LANE + v) % N_CHAN;
            for (int t = 0; t < NUM_TABLES; t++)
                if (!loaded[t][e])
                    queue_load(param_sel_t'(t), IDX_W'(e), rand_q88());
        end
        it.func = FUNC_COMPUTE;
        it.sel  = param_sel_t'($urandom_range(3));
        it.idx  = idx;
        it.wval = WORD_W'($urandom);
        it.x    = x;
        last_idx = idx;
        queue_item(it);
    endtask

    // Random part of a phase: mostly computes, a quarter of them stray loads that overwrite
    // entries at random. Half of the computes revisit the last channel group, in per-lane
    // mode through an aliased index that wraps onto the same table entries.
    task automatic queue_random(int count);
        int               stop_at;
        logic [IDX_W-1:0] idx;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            if ($urandom_range(99) < 25)
                queue_load(param_sel_t'($urandom_range(3)), IDX_W'($urandom), rand_q88());
            else
            begin
                if ($urandom_range(1) == 0)
                    idx = IDX_W'($urandom);
                else if (cfg_mode == MODE_BROADCAST)
                    idx = last_idx;
                else
                    idx = {3'($urandom), last_idx[4:0]};
                queue_compute(idx, rand_lanes());
            end
        end
    endtask

    // Register write followed by a read-back, each with a setup phase and an access phase.
    task automatic write_weight_mode(wmode_t mode);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_WEIGHT_MODE) << REG_ADDR_LSB;
        pwdata  <= PDATA_W'(mode);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cfg_mode = mode;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(mode))
        begin
            $display("%0t: weight_mode read-back expected %h got %h",
                     $time, PDATA_W'(mode), prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every item has been taken and every result has arrived, then lets a
    // drain period pass.
    task automatic wait_idle();
        while (items_accepted != items_queued || y_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: drives queued items onto the input stream with random gaps.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                bn_apply(cur_item);
                items_accepted++;
            end
            // An item that has not been taken stays on the bus unchanged.
            if (s_tvalid && !s_tready)
                ;
            else if (src_wait > 0)
            begin
                src_wait--;
                s_tvalid <= 1'b0;
            end
            else if (item_queue.size() > 0)
            begin
                cur_item = item_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_item.x, cur_item.wval, cur_item.idx};
                s_tuser  <= {cur_item.sel, cur_item.func};
                src_wait = pick_gap(src_idle_pct);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each result item and stalls the output at random. A hold-off
    // request makes it stall for a long stretch so that the block backs up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (y_expect.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none got %h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    for (int v = 0; v < N_LANE; v++)
                    begin
                        if (m_tdata[v*WORD_W +: WORD_W] !== y_expect[0][v])
                        begin
                            $display("%0t: y_lane%0d expected %h got %h", $time, v,
                                     y_expect[0][v], m_tdata[v*WORD_W +: WORD_W]);
                            error_count++;
                        end
                    end
                    void'(y_expect.pop_front());
                end
            end
            if (hold_served != hold_asks)
            begin
                hold_served++;
                sink_wait = HOLD_CYCLES;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_wait = pick_gap(sink_idle_pct);
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAIL batch_norm_vector_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int e = 0; e < N_CHAN; e++)
        begin
            mean_tab[e]  = '0;
            rvar_tab[e]  = '0;
            gamma_tab[e] = '0;
            beta_tab[e]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Per-lane mode straight from reset, without touching the register.
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        queue_random(220);
        wait_idle();

        // Broadcast mode with the directed items first.
        write_weight_mode(MODE_BROADCAST);
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        // Scale of one half over 256: lane results of exactly +0.5, -0.5, +1.5 and -1.5 LSB, where the
        // halves must round upwards, then the extremes of the activation word.
        queue_load(SEL_MEAN, 8'd0, 16'h0000);
        queue_load(SEL_RVAR, 8'd0, 16'h0100);
        queue_load(SEL_GAMMA, 8'd0, 16'h0080);
        queue_load(SEL_BETA, 8'd0, 16'h0000);
        queue_compute(8'd0, {16'h0001, 16'h8000, 16'h7FFF, 16'h0000,
                             16'hFD00, 16'h0300, 16'hFF00, 16'h0100});
        // Largest positive product plus largest beta: saturation upwards, and a zero
        // difference where the activation equals the most negative mean.
        queue_load(SEL_MEAN, 8'd255, 16'h8000);
        queue_load(SEL_RVAR, 8'd255, 16'h7FFF);
        queue_load(SEL_GAMMA, 8'd255, 16'h7FFF);
        queue_load(SEL_BETA, 8'd255, 16'h7FFF);
        queue_compute(8'd255, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                               16'h0001, 16'h8000, 16'h7FFF, 16'h8000});
        // Negative scale and most negative beta: the widest difference drives the sum
        // past the upper limit, and a zero difference leaves only the negative beta.
        queue_load(SEL_MEAN, 8'd1, 16'h7FFF);
        queue_load(SEL_RVAR, 8'd1, 16'h8000);
        queue_load(SEL_GAMMA, 8'd1, 16'h7FFF);
        queue_load(SEL_BETA, 8'd1, 16'h8000);
        queue_compute(8'd1, {16'h7FFF, 16'h8000, 16'h7FFE, 16'h0000,
                             16'h7FFF, 16'h8001, 16'hFFFF, 16'h8000});
        queue_random(280);
        wait_idle();

        // Back to per-lane with the sender never idling, and one long hold-off at the
        // receiver so that the lane stages fill and the input stalls.
        write_weight_mode(MODE_PER_LANE);
        src_idle_pct  = 0;
        sink_idle_pct = 10;
        queue_random(300);
        hold_asks++;
        wait_idle();

        // A stretch with no idling at all on either side.
        write_weight_mode(MODE_BROADCAST);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_random(300);
        wait_idle();

        // Heavy idling on both sides.
        write_weight_mode(MODE_PER_LANE);
        src_idle_pct  = 40;
        sink_idle_pct = 40;
        queue_random(300);
        wait_idle();

        if (error_count == 0)
            $display("PASS batch_norm_vector_unit");
        else
            $display("FAIL batch_norm_vector_unit");
        $finish;
    end

endmodule
